// File: hdl/kwm_pkg.sv
// Shared constants and types for the k-way sorted stream merge.
// Used by kwm_ctrl, kwm_datapath and k_way_sorted_stream_merge; depends on nothing.
package kwm_pkg;

	localparam int unsigned SRC_W           = 3;
	localparam int unsigned VAL_W           = 64;
	localparam int unsigned CNT_W           = 4;
	localparam int unsigned SRC_SLOTS       = 8;
	localparam int unsigned MAX_SOURCES_DEF = 8;
	localparam int unsigned TDATA_W         = 72;
	localparam int unsigned PAD_W           = TDATA_W - VAL_W - SRC_W;

	localparam logic [CNT_W-1:0] CFG_RESET = 4'd8;

	typedef struct packed {
		logic write_head;
		logic emit;
	} kwm_cmd_t;

	typedef struct packed {
		logic can_emit;
		logic best_last;
	} kwm_sts_t;

endpackage

// File: hdl/kwm_datapath.sv
// Datapath of the merge: head registers, pairwise order matrix, winner select
// and the result register. Depends on kwm_pkg.
module kwm_datapath import kwm_pkg::*; #(
	parameter int unsigned MAX_SOURCES = MAX_SOURCES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic [SRC_W-1:0] in_source,
	input  logic [VAL_W-1:0] in_value,
	input  logic             in_last,
	input  kwm_cmd_t         cmd,
	output kwm_sts_t         sts,
	output logic [VAL_W-1:0] out_smallest,
	output logic [SRC_W-1:0] out_source,
	output logic             out_done
);

	localparam int unsigned SLOTS = (MAX_SOURCES < SRC_SLOTS) ? MAX_SOURCES : SRC_SLOTS;
	localparam int unsigned IDX_W = $clog2(SLOTS);

	logic [CNT_W-1:0] cfg_q;
	logic [CNT_W-1:0] n_eff;
	logic [VAL_W-1:0] hv_q [SLOTS];
	logic [SLOTS-1:0] lt_q [SLOTS];
	logic [SLOTS-1:0] last_q;
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] fin_q;
	logic [SLOTS-1:0] active;
	logic [SLOTS-1:0] cand;
	logic [SLOTS-1:0] win;
	logic [SLOTS-1:0] best_oh;
	logic [SLOTS-1:0] fin_after;
	logic [IDX_W-1:0] wr_idx;
	logic [IDX_W-1:0] best_idx;
	logic             take;
	logic             ready_all;
	logic             done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			cfg_q <= cfg_data;
		end
	end

	always_comb begin
		priority if (cfg_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (cfg_q > CNT_W'(SLOTS)) begin
			n_eff = CNT_W'(SLOTS);
		end else begin
			n_eff = cfg_q;
		end
	end

	assign wr_idx = in_source[IDX_W-1:0];
	assign take   = cmd.write_head && ({1'b0, in_source} < n_eff) &&
	                !valid_q[wr_idx] && !fin_q[wr_idx];

	// A source wins when it beats every other candidate; ties go to the lower index.
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			active[i] = CNT_W'(i) < n_eff;
			cand[i]   = active[i] && valid_q[i] && !fin_q[i];
		end
		for (int i = 0; i < SLOTS; i++) begin
			win[i] = cand[i];
			for (int j = 0; j < SLOTS; j++) begin
				if (j != i && cand[j]) begin
					if (j < i) begin
						win[i] = win[i] && lt_q[i][j];
					end else begin
						win[i] = win[i] && !lt_q[j][i];
					end
				end
			end
		end
		best_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (win[i]) begin
				best_idx = IDX_W'(i);
			end
		end
		best_oh           = '0;
		best_oh[best_idx] = |win;
	end

	assign ready_all     = &(~active | fin_q | valid_q);
	assign fin_after     = fin_q | (best_oh & last_q);
	assign done          = &(fin_after | ~active);
	assign sts.can_emit  = ready_all && (|cand);
	assign sts.best_last = last_q[best_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			last_q  <= '0;
			fin_q   <= '0;
		end else if (take) begin
			valid_q[wr_idx] <= 1'b1;
			last_q[wr_idx]  <= in_last;
		end else if (cmd.emit) begin
			valid_q[best_idx] <= 1'b0;
			fin_q             <= fin_after;
		end
	end

	// The order matrix holds lt_q[i][j] = head i below head j for every written pair.
	always_ff @(posedge clk) begin
		if (take) begin
			hv_q[wr_idx] <= in_value;
			for (int j = 0; j < SLOTS; j++) begin
				if (IDX_W'(j) != wr_idx) begin
					lt_q[wr_idx][j] <= in_value < hv_q[j];
					lt_q[j][wr_idx] <= hv_q[j] < in_value;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_smallest <= hv_q[best_idx];
			out_source   <= SRC_W'(best_idx);
			out_done     <= done;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_valid_finished: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q & fin_q) == '0)
		else $error("A finished source still holds a head.");

	a_emit_valid_head: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> valid_q[best_idx] && sts.can_emit)
		else $error("Result taken from a source without a head.");

	a_emit_clears_head: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> $countones(valid_q) == $countones($past(valid_q)) - 1)
		else $error("Emitted head was not released.");
`endif

endmodule

// File: hdl/kwm_ctrl.sv
// Controller of the merge: accept/evaluate state machine and the result valid flag.
// Depends on kwm_pkg.
module kwm_ctrl import kwm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  kwm_sts_t sts,
	output kwm_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EVAL = 1'b1;

	logic state_q;
	logic state_d;
	logic m_valid_q;
	logic slot_free;

	assign slot_free = !m_valid_q || m_tready;
	assign s_tready  = state_q == ST_IDLE;
	assign m_tvalid  = m_valid_q;

	always_comb begin
		state_d        = state_q;
		cmd.write_head = 1'b0;
		cmd.emit       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.write_head = 1'b1;
					state_d        = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!sts.can_emit) begin
					state_d = ST_IDLE;
				end else if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.best_last ? ST_EVAL : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> state_q == ST_EVAL)
		else $error("Accepted transaction was not evaluated.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit && m_valid_q && !m_tready))
		else $error("Result register overwritten before it was taken.");

	a_plain_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !sts.best_last) |=> state_q == ST_IDLE)
		else $error("Evaluation continued after a head that was not last.");
`endif

endmodule

// File: hdl/k_way_sorted_stream_merge.sv
// Top level of the k-way sorted stream merge: ports, packing, and the
// controller and datapath instances. Depends on kwm_pkg, kwm_ctrl, kwm_datapath.
//
// Channel  Direction  Handshake                  Payload
// s_axis   in         s_axis_tvalid/tready       tdata: source, value; tlast: last
// m_axis   out        m_axis_tvalid/tready       tdata: smallest, from_source;
//                                                tlast: merge_done
// cfg      in         cfg_valid/cfg_ready        cfg_data: active_sources
//
// An input transaction stores the head and updates the pairwise order matrix, then,
// if every active open source holds a head, selects the smallest and loads the result.
// Each result whose head was marked last is followed by a search for a further result.
// The output register lets the next input transaction in while a result waits.
// A stalled output holds the evaluation until the result register drains.
// Reset clears all head and finished flags and sets active_sources to 8.
module k_way_sorted_stream_merge import kwm_pkg::*; #(
	parameter int unsigned MAX_SOURCES = MAX_SOURCES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CNT_W-1:0]   cfg_data,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,   // source [2:0], value [66:3], zeros above
	input  logic               s_axis_tlast,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,   // smallest [63:0], from_source [66:64], zeros above
	output logic               m_axis_tlast
);

	kwm_cmd_t         cmd;
	kwm_sts_t         sts;
	logic [VAL_W-1:0] out_smallest;
	logic [SRC_W-1:0] out_source;

	assign cfg_ready = 1'b1;

	kwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kwm_datapath #(
		.MAX_SOURCES (MAX_SOURCES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.in_source    (s_axis_tdata[SRC_W-1:0]),
		.in_value     (s_axis_tdata[SRC_W+VAL_W-1:SRC_W]),
		.in_last      (s_axis_tlast),
		.cmd          (cmd),
		.sts          (sts),
		.out_smallest (out_smallest),
		.out_source   (out_source),
		.out_done     (m_axis_tlast)
	);

	assign m_axis_tdata = {{PAD_W{1'b0}}, out_source, out_smallest};

endmodule

// File: sim/k_way_sorted_stream_merge_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for k_way_sorted_stream_merge: directed and random merge traffic
// under bursty input and output stalls, checked against an in-line merge predictor.
// Depends on kwm_pkg and the k_way_sorted_stream_merge RTL.
module k_way_sorted_stream_merge_test;
	import kwm_pkg::*;

	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned SETTLE_CYCLES = 24;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam logic [VAL_W-1:0] VAL_MAX  = {VAL_W{1'b1}};

	typedef struct packed {
		logic [VAL_W-1:0] smallest;
		logic [SRC_W-1:0] from_source;
		logic             merge_done;
	} merge_out_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CNT_W-1:0]   cfg_data;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata;
	logic               s_axis_tlast;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               m_axis_tlast;

	merge_out_t       expected_merge[$];
	logic [VAL_W-1:0] head_val [SRC_SLOTS];
	bit               head_last[SRC_SLOTS];
	bit               head_full[SRC_SLOTS];
	bit               run_done [SRC_SLOTS];
	logic [CNT_W-1:0] source_count;

	int unsigned mismatch_count;
	int unsigned quiet_cycles;
	int unsigned burst_left;
	int unsigned hold_left;
	int unsigned pattern_left;
	logic [2:0]  pattern_pos;
	logic [7:0]  ready_mask;
	bit          hold_request;

	k_way_sorted_stream_merge dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	function automatic int unsigned live_count();
		int unsigned n;
		n = source_count;
		if (n == 0)
			n = 1;
		if (n > MAX_SOURCES_DEF)
			n = MAX_SOURCES_DEF;
		return n;
	endfunction

	function automatic bit head_slot_open(input logic [SRC_W-1:0] src);
		return (src < live_count()) && !head_full[src] && !run_done[src];
	endfunction

	function automatic logic [VAL_W-1:0] random_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return VAL_MAX;
			2, 3: return VAL_W'($urandom_range(0, 7));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic advance_merge(input logic [SRC_W-1:0] src, input logic [VAL_W-1:0] val,
			input logic lst);
		int unsigned n;
		int unsigned emitted;
		int unsigned best;
		bit          all_full;
		bit          any_open;
		bit          all_done;
		merge_out_t  result;
		n = live_count();
		emitted = 0;
		if (head_slot_open(src)) begin
			head_val[src] = val;
			head_last[src] = lst;
			head_full[src] = 1'b1;
		end
		while (1) begin
			all_full = 1'b1;
			any_open = 1'b0;
			best = 0;
			for (int unsigned i = 0; i < n; i++) begin
				if (run_done[i])
					continue;
				if (!head_full[i]) begin
					all_full = 1'b0;
					break;
				end
				if (!any_open || head_val[i] < head_val[best])
					best = i;
				any_open = 1'b1;
			end
			if (!all_full || !any_open || emitted >= n)
				break;
			head_full[best] = 1'b0;
			if (head_last[best])
				run_done[best] = 1'b1;
			all_done = 1'b1;
			for (int unsigned i = 0; i < n; i++)
				if (!run_done[i])
					all_done = 1'b0;
			result.smallest = head_val[best];
			result.from_source = SRC_W'(best);
			result.merge_done = all_done;
			expected_merge = {expected_merge, result};
			emitted++;
			if (!run_done[best])
				break;
		end
	endtask

	task automatic send_item(input logic [SRC_W-1:0] src, input logic [VAL_W-1:0] val,
			input logic lst);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 8);
		end
		burst_left--;
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {{PAD_W{1'b0}}, val, src};
		s_axis_tlast = lst;
		do @(posedge clk); while (!s_axis_tready);
		advance_merge(src, val, lst);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		burst_left = 0;
		while (expected_merge.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_source_count(input logic [CNT_W-1:0] cnt);
		wait_drained();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = cnt;
		do @(posedge clk); while (!cfg_ready);
		source_count = cnt;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic random_traffic(input int unsigned n_items);
		int unsigned      sent;
		int unsigned      open_runs;
		int unsigned      tries;
		logic [SRC_W-1:0] src;
		logic [SRC_W-1:0] open_src[$];
		sent = 0;
		while (sent < n_items) begin
			open_src.delete();
			open_runs = 0;
			for (int unsigned i = 0; i < SRC_SLOTS; i++) begin
				if (i < live_count() && !run_done[i])
					open_runs++;
				if (head_slot_open(SRC_W'(i)))
					open_src = {open_src, SRC_W'(i)};
			end
			if (open_runs == 0)
				break;
			if (open_src.size() == 0 || $urandom_range(0, 4) == 0) begin
				src = 0;
				tries = 0;
				do begin
					src = SRC_W'($urandom_range(0, SRC_SLOTS - 1));
					tries++;
				end while (head_slot_open(src) && tries < 16);
				if (head_slot_open(src))
					src = 0;
				send_item(src, random_value(), 1'($urandom_range(0, 1)));
			end else begin
				src = open_src[$urandom_range(0, open_src.size() - 1)];
				send_item(src, random_value(), open_runs > 3 && $urandom_range(0, 29) == 0);
				sent++;
			end
		end
	endtask

	task automatic test_single_source();
		set_source_count(4'd1);
		send_item(3'd0, VAL_MAX, 1'b0);
		send_item(3'd5, 64'd123, 1'b1);
		send_item(3'd0, 64'd0, 1'b0);
		send_item(3'd0, 64'h0123_4567_89AB_CDEF, 1'b1);
		send_item(3'd0, 64'd42, 1'b1);
		set_source_count(4'd0);
		send_item(3'd0, 64'd7, 1'b0);
		send_item(3'd1, 64'd8, 1'b1);
	endtask

	task automatic test_saturated_count_ties();
		set_source_count(4'd15);
		send_item(3'd1, VAL_MAX, 1'b0);
		send_item(3'd2, 64'd5, 1'b0);
		send_item(3'd3, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
		send_item(3'd4, 64'd100, 1'b0);
		send_item(3'd5, 64'd5, 1'b0);
		send_item(3'd6, 64'h8000_0000_0000_0000, 1'b0);
		send_item(3'd3, 64'd1, 1'b1);
		send_item(3'd7, 64'd7, 1'b0);
		send_item(3'd2, 64'd9, 1'b0);
		send_item(3'd5, VAL_MAX, 1'b0);
		send_item(3'd7, 64'd6, 1'b0);
	endtask

	task automatic test_random_merge(input logic [CNT_W-1:0] cnt, input int unsigned n_items);
		set_source_count(cnt);
		random_traffic(n_items);
	endtask

	task automatic test_output_backpressure();
		hold_request = 1'b1;
		random_traffic(20);
	endtask

	task automatic test_sender_pause();
		wait_drained();
		random_traffic(10);
	endtask

	task automatic test_finish_all_runs();
		logic [SRC_W-1:0] open_src[$];
		bit               runs_left;
		set_source_count(4'd8);
		runs_left = 1'b1;
		while (runs_left) begin
			open_src.delete();
			runs_left = 1'b0;
			for (int unsigned i = 0; i < SRC_SLOTS; i++) begin
				if (!run_done[i])
					runs_left = 1'b1;
				if (head_slot_open(SRC_W'(i)))
					open_src = {open_src, SRC_W'(i)};
			end
			if (!runs_left)
				break;
			if (open_src.size() == 0)
				send_item(3'd0, 64'd0, 1'b0);
			else
				send_item(open_src[0], VAL_MAX - VAL_W'(open_src[0]), 1'b1);
		end
		send_item(3'd6, 64'd1, 1'b0);
		send_item(3'd1, 64'd2, 1'b1);
	endtask

	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready = 1'b0;
		end else begin
			if (pattern_left == 0) begin
				pattern_left = $urandom_range(16, 96);
				ready_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
				if (ready_mask == 8'h00)
					ready_mask = 8'h01;
			end
			pattern_left--;
			m_axis_tready = ready_mask[pattern_pos];
			pattern_pos++;
		end
	end

	always @(posedge clk) begin
		merge_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_merge.size() == 0) begin
				$display("%0t: expected no result, actual smallest %h from_source %0d merge_done %0b",
					$time, m_axis_tdata[VAL_W-1:0], m_axis_tdata[VAL_W+SRC_W-1:VAL_W],
					m_axis_tlast);
				mismatch_count++;
			end else begin
				want = expected_merge.pop_front();
				if (m_axis_tdata[VAL_W-1:0] !== want.smallest) begin
					$display("%0t: smallest expected %h actual %h", $time, want.smallest,
						m_axis_tdata[VAL_W-1:0]);
					mismatch_count++;
				end
				if (m_axis_tdata[VAL_W+SRC_W-1:VAL_W] !== want.from_source) begin
					$display("%0t: from_source expected %0d actual %0d", $time,
						want.from_source, m_axis_tdata[VAL_W+SRC_W-1:VAL_W]);
					mismatch_count++;
				end
				if (m_axis_tlast !== want.merge_done) begin
					$display("%0t: merge_done expected %0b actual %0b", $time,
						want.merge_done, m_axis_tlast);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		mismatch_count = 0;
		quiet_cycles = 0;
		burst_left = 0;
		hold_left = 0;
		pattern_left = 0;
		pattern_pos = '0;
		ready_mask = 8'hFF;
		hold_request = 1'b0;
		source_count = CFG_RESET;
		for (int unsigned i = 0; i < SRC_SLOTS; i++) begin
			head_val[i] = '0;
			head_last[i] = 1'b0;
			head_full[i] = 1'b0;
			run_done[i] = 1'b0;
		end
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_single_source();
		test_saturated_count_ties();
		test_random_merge(4'd8, 25);
		test_random_merge(4'd4, 20);
		test_random_merge(4'd15, 20);
		test_output_backpressure();
		test_sender_pause();
		test_finish_all_runs();
		wait_drained();

		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
